[src/vce_pkg.sv]
package vce_pkg;

	localparam int CYCLES_PER_LINE_DEF  = 1365;
	localparam int LINES_PER_FRAME_DEF  = 263;
	localparam int HSYNC_LOW_CYCLES_DEF = 237;
	localparam int VSYNC_DELAY          = 30;

	localparam int PAL_DEPTH = 512;
	localparam int PAL_AW    = 9;
	localparam int COL_W     = 11;
	localparam int LINE_W    = 9;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_BUS_RD = 3'd1,
		OP_BUS_WR = 3'd2,
		OP_DIR_RD = 3'd3,
		OP_DIR_WR = 3'd4
	} opcode_t;

	localparam logic [2:0] REG_CTRL    = 3'd0;
	localparam logic [2:0] REG_ADDR_LO = 3'd2;
	localparam logic [2:0] REG_ADDR_HI = 3'd3;
	localparam logic [2:0] REG_DATA_LO = 3'd4;
	localparam logic [2:0] REG_DATA_HI = 3'd5;

	typedef enum logic [2:0] {
		RS_NONE,
		RS_PIX,
		RS_LO,
		RS_HI_FE,
		RS_HI,
		RS_FF
	} rsel_t;

	typedef struct packed {
		logic              rd;
		logic              wr_lo;
		logic              wr_hi;
		logic [PAL_AW-1:0] addr;
		logic [7:0]        data;
	} pal_req_t;

endpackage

[src/vce_palette.sv]
module vce_palette (
	input  logic              clk,
	input  logic              arst_n,
	input  vce_pkg::pal_req_t req,
	output logic              busy,
	output logic [7:0]        rd_lo,
	output logic              rd_hi
);
	import vce_pkg::*;

	logic [7:0]        lo_mem [PAL_DEPTH];
	logic              hi_mem [PAL_DEPTH];
	logic              clr_active_q;
	logic [PAL_AW-1:0] clr_addr_q;

	assign busy = clr_active_q;

	// zero sweep after reset, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == PAL_AW'(PAL_DEPTH - 1))
				clr_active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			lo_mem[clr_addr_q] <= '0;
			hi_mem[clr_addr_q] <= 1'b0;
		end else begin
			if (req.wr_lo)
				lo_mem[req.addr] <= req.data;
			if (req.wr_hi)
				hi_mem[req.addr] <= req.data[0];
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			rd_lo <= lo_mem[req.addr];
			rd_hi <= hi_mem[req.addr];
		end
	end

endmodule

[src/video_colour_encoder_timing_palette.sv]
// Colour encoder with a 512 x 9 palette and a line/frame timing generator.
// Input channel (in_valid/in_ready): one word per master-clock tick or bus
// access, selected by opcode: tick, bus register read/write, or direct
// palette byte read/write. Output channel (out_valid/out_ready): exactly one
// result word per input word, in order: palette colour with greyscale bit on
// a tick, read byte on reads, and the sync levels, column and line after the
// word.
// A word is registered in the input stage and its result in the output stage.
// Throughput is one word per cycle while the palette is not busy and the
// receiver is ready; the palette has one read/write port used once per word.
// An input stage and an output stage decouple the channels, so one word is
// still taken while a result waits; when the receiver stalls, in_ready drops
// once both stages are full and the result holds steady.
// After reset the palette is swept to zero, one entry per cycle, and in_ready
// stays low while the sweep runs. Sync levels reset high, counters to zero,
// and the pixel rate to its slowest setting.
module video_colour_encoder_timing_palette #(
	parameter int CYCLES_PER_LINE  = vce_pkg::CYCLES_PER_LINE_DEF,
	parameter int LINES_PER_FRAME  = vce_pkg::LINES_PER_FRAME_DEF,
	parameter int HSYNC_LOW_CYCLES = vce_pkg::HSYNC_LOW_CYCLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [9:0]  offset,
	input  logic [7:0]  wdata,
	input  logic [8:0]  pixel_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  pixel_out,
	output logic [7:0]  read_data,
	output logic        hsync_level,
	output logic        vsync_level,
	output logic        pixel_taken,
	output logic [10:0] column,
	output logic [8:0]  line
);
	import vce_pkg::*;

	localparam logic [COL_W-1:0]  H_LAST   = COL_W'(CYCLES_PER_LINE - 1);
	localparam logic [COL_W-1:0]  HS_COL   = COL_W'(CYCLES_PER_LINE - HSYNC_LOW_CYCLES);
	localparam logic [COL_W:0]    VS_COL   =
		(COL_W+1)'(CYCLES_PER_LINE - HSYNC_LOW_CYCLES + VSYNC_DELAY);
	localparam logic [LINE_W-1:0] V_LAST   = LINE_W'(LINES_PER_FRAME - 1);
	localparam logic [LINE_W-1:0] VS_FIRST = LINE_W'(LINES_PER_FRAME - 4);

	function automatic logic [1:0] div_next(input logic [1:0] div, input logic [2:0] cpp);
		logic [2:0] n;
		n = {1'b0, div} + 3'd1;
		case (cpp)
			3'd2:    div_next = {1'b0, n[0]};
			3'd3:    div_next = (n >= 3'd3) ? 2'(n - 3'd3) : n[1:0];
			default: div_next = n[1:0];
		endcase
	endfunction

	// input stage
	logic        valid_s1;
	logic [2:0]  op_s1;
	logic [9:0]  off_s1;
	logic [7:0]  wdata_s1;
	logic [8:0]  idx_s1;

	// output stage
	logic        valid_s2;
	rsel_t       rsel_s2;
	logic        taken_s2;

	// block state
	logic [PAL_AW-1:0] paddr_q;
	logic              grey_q;
	logic [2:0]        cpp_q;
	logic [1:0]        div_q;
	logic [8:0]        latched_q;
	logic [COL_W-1:0]  hpos_q;
	logic [LINE_W-1:0] vpos_q;
	logic              hs_q;
	logic              vs_q;

	logic              pal_busy;
	logic [7:0]        pal_lo;
	logic              pal_hi;
	logic              adv;

	pal_req_t          req;
	logic [PAL_AW-1:0] paddr_d;
	logic              grey_d;
	logic [2:0]        cpp_d;
	logic [1:0]        div_d;
	logic              latch_en;
	logic [COL_W-1:0]  hpos_d;
	logic [LINE_W-1:0] vpos_d;
	logic              hs_d;
	logic              vs_d;
	rsel_t             rsel_d;
	logic              taken_d;

	assign adv      = valid_s1 && !pal_busy && (!valid_s2 || out_ready);
	assign in_ready = !pal_busy && (!valid_s1 || adv);

	always_comb begin
		req      = '0;
		req.rd   = adv;
		req.addr = paddr_q;
		req.data = wdata_s1;
		paddr_d  = paddr_q;
		grey_d   = grey_q;
		cpp_d    = cpp_q;
		div_d    = div_q;
		latch_en = 1'b0;
		hpos_d   = hpos_q;
		vpos_d   = vpos_q;
		hs_d     = hs_q;
		vs_d     = vs_q;
		rsel_d   = RS_NONE;
		taken_d  = 1'b0;
		case (op_s1)
			OP_TICK: begin
				rsel_d = RS_PIX;
				if (div_q == 2'd0) begin
					latch_en = 1'b1;
					taken_d  = 1'b1;
					req.addr = idx_s1;
				end else begin
					req.addr = latched_q;
				end
				div_d  = div_next(div_q, cpp_q);
				hpos_d = (hpos_q == H_LAST) ? '0 : hpos_q + 1'b1;
				if (hpos_d == HS_COL) begin
					hs_d = 1'b0;
				end else if (hpos_d == '0) begin
					hs_d   = 1'b1;
					div_d  = 2'd0;
					vpos_d = (vpos_q == V_LAST) ? '0 : vpos_q + 1'b1;
				end else if ({1'b0, hpos_d} == VS_COL && vpos_q >= VS_FIRST) begin
					vs_d = (vpos_q == V_LAST);
				end
			end
			OP_BUS_RD: begin
				case (off_s1[2:0])
					REG_DATA_LO: rsel_d = RS_LO;
					REG_DATA_HI: begin
						rsel_d  = RS_HI_FE;
						paddr_d = paddr_q + 1'b1;
					end
					default:     rsel_d = RS_FF;
				endcase
			end
			OP_BUS_WR: begin
				case (off_s1[2:0])
					REG_CTRL: begin
						grey_d = wdata_s1[7];
						cpp_d  = wdata_s1[1] ? 3'd2 : (wdata_s1[0] ? 3'd3 : 3'd4);
					end
					REG_ADDR_LO: paddr_d = {paddr_q[8], wdata_s1};
					REG_ADDR_HI: paddr_d = {wdata_s1[0], paddr_q[7:0]};
					REG_DATA_LO: req.wr_lo = adv;
					REG_DATA_HI: begin
						req.wr_hi = adv;
						paddr_d   = paddr_q + 1'b1;
					end
					default: ;
				endcase
			end
			OP_DIR_RD: begin
				req.addr = off_s1[9:1];
				rsel_d   = off_s1[0] ? RS_HI : RS_LO;
			end
			OP_DIR_WR: begin
				req.addr = off_s1[9:1];
				if (off_s1[0])
					req.wr_hi = adv;
				else
					req.wr_lo = adv;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			rsel_s2  <= RS_NONE;
			taken_s2 <= 1'b0;
			paddr_q  <= '0;
			grey_q   <= 1'b0;
			cpp_q    <= 3'd4;
			div_q    <= 2'd0;
			hpos_q   <= '0;
			vpos_q   <= '0;
			hs_q     <= 1'b1;
			vs_q     <= 1'b1;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv) begin
				valid_s2 <= 1'b1;
				rsel_s2  <= rsel_d;
				taken_s2 <= taken_d;
				paddr_q  <= paddr_d;
				grey_q   <= grey_d;
				cpp_q    <= cpp_d;
				div_q    <= div_d;
				hpos_q   <= hpos_d;
				vpos_q   <= vpos_d;
				hs_q     <= hs_d;
				vs_q     <= vs_d;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= opcode;
			off_s1   <= offset;
			wdata_s1 <= wdata;
			idx_s1   <= pixel_index;
		end
		if (adv && latch_en)
			latched_q <= idx_s1;
	end

	vce_palette u_palette (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.busy   (pal_busy),
		.rd_lo  (pal_lo),
		.rd_hi  (pal_hi)
	);

	// state registers only move when a word enters the output stage
	always_comb begin
		pixel_out = '0;
		read_data = '0;
		case (rsel_s2)
			RS_PIX:   pixel_out = {grey_q, pal_hi, pal_lo};
			RS_LO:    read_data = pal_lo;
			RS_HI_FE: read_data = {7'h7f, pal_hi};
			RS_HI:    read_data = {7'h00, pal_hi};
			RS_FF:    read_data = 8'hff;
			default:  ;
		endcase
	end

	assign out_valid   = valid_s2;
	assign pixel_taken = taken_s2;
	assign hsync_level = hs_q;
	assign vsync_level = vs_q;
	assign column      = hpos_q;
	assign line        = vpos_q;

endmodule
